// File: hdl/rhsv_pkg.sv
// Shared types and constants of the RGB to HSV conversion unit.
`default_nettype none

package rhsv_pkg;

    // Widths of the pixel samples and the results.
    localparam int SAMPLE_W = 10;
    localparam int HUE_W    = 9;

    // Dividend width: 1023 * 1023 needs 20 bits.
    localparam int NUM_W    = 20;

    // Quotient bits per division, one per divider stage.
    localparam int QUOT_W   = 10;

    // Color-wheel constants.
    localparam logic [HUE_W-1:0]    HUE_SECTOR = 9'd60;
    localparam logic [HUE_W-1:0]    HUE_GREEN  = 9'd120;
    localparam logic [HUE_W-1:0]    HUE_BLUE   = 9'd240;
    localparam logic [HUE_W-1:0]    HUE_FULL   = 9'd360;
    localparam logic [SAMPLE_W-1:0] SAT_SCALE  = 10'd1023;

    // Result of the classify stage.
    typedef struct packed {
        logic [SAMPLE_W-1:0] bright;
        logic [SAMPLE_W-1:0] chroma;
        logic [SAMPLE_W-1:0] diff;
        logic                neg;
        logic [HUE_W-1:0]    bias;
    } t_cls;

    // State carried through the multiply and divider stages.
    typedef struct packed {
        logic [NUM_W-1:0]    hrem;
        logic [NUM_W-1:0]    srem;
        logic [QUOT_W-1:0]   hq;
        logic [QUOT_W-1:0]   sq;
        logic [SAMPLE_W-1:0] chroma;
        logic [SAMPLE_W-1:0] bright;
        logic                neg;
        logic [HUE_W-1:0]    bias;
    } t_div;

endpackage

`default_nettype wire

// File: hdl/rhsv_pixel_if.sv
// Handshake channel that carries one RGB pixel.
`default_nettype none

interface rhsv_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [rhsv_pkg::SAMPLE_W-1:0]     red;
    logic [rhsv_pkg::SAMPLE_W-1:0]     green;
    logic [rhsv_pkg::SAMPLE_W-1:0]     blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: hdl/rhsv_result_if.sv
// Handshake channel that carries one HSV result.
`default_nettype none

interface rhsv_result_if;
    logic                              valid;
    logic                              ready;
    logic [rhsv_pkg::HUE_W-1:0]        hue;
    logic [rhsv_pkg::SAMPLE_W-1:0]     saturation;
    logic [rhsv_pkg::SAMPLE_W-1:0]     brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/rgb_to_hsv_integer_unit.sv
// Pipelined integer RGB to HSV converter, one pixel per clock while the output is not stalled.
`default_nettype none

// The unit converts one pixel per clock cycle. Each pixel passes through 13 register
// stages, the last of which presents its result at the output. The depth
// is set by the two restoring dividers (hue and saturation), which run side by side
// and resolve one quotient bit in each of ten register stages; one classify stage,
// one multiply stage and the output register make up the rest. The pipeline
// advances as a whole: when a result waits at the output and is not taken, the
// input stops accepting pixels until it is. Hue is in whole degrees 0..360,
// saturation is floor(1023 * chroma / max), brightness is the largest sample.
// Grey pixels give hue 0 and black pixels give saturation 0. No reset-time
// sweep is needed; the unit accepts pixels right after reset.

module rgb_to_hsv_integer_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rhsv_pixel_if.sink    i_pix,
    rhsv_result_if.source o_res
);

    localparam int NDIV = rhsv_pkg::QUOT_W;

    // Pipeline enable: move everything when the output slot is free or taken.
    logic r_out_valid;
    logic en;

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;

    // Classify stage: max, min, chroma, hue branch and signed difference.
    rhsv_pkg::t_cls r_cls;
    rhsv_pkg::t_cls n_cls;
    logic           r_cls_valid;

    always_comb begin
        logic [rhsv_pkg::SAMPLE_W-1:0] hi;
        logic [rhsv_pkg::SAMPLE_W-1:0] lo;
        logic [rhsv_pkg::SAMPLE_W-1:0] pos;
        logic [rhsv_pkg::SAMPLE_W-1:0] ngv;
        hi = i_pix.red;
        lo = i_pix.red;
        if (i_pix.green > hi) hi = i_pix.green;
        if (i_pix.blue > hi)  hi = i_pix.blue;
        if (i_pix.green < lo) lo = i_pix.green;
        if (i_pix.blue < lo)  lo = i_pix.blue;

        // Red wins ties over green, green over blue.
        if (hi == i_pix.red) begin
            pos       = i_pix.green;
            ngv       = i_pix.blue;
            n_cls.bias = (i_pix.green >= i_pix.blue) ? '0 : rhsv_pkg::HUE_FULL;
        end else if (hi == i_pix.green) begin
            pos       = i_pix.blue;
            ngv       = i_pix.red;
            n_cls.bias = rhsv_pkg::HUE_GREEN;
        end else begin
            pos       = i_pix.red;
            ngv       = i_pix.green;
            n_cls.bias = rhsv_pkg::HUE_BLUE;
        end

        n_cls.bright = hi;
        n_cls.chroma = hi - lo;
        n_cls.neg    = (pos < ngv);
        n_cls.diff   = (pos >= ngv) ? (pos - ngv) : (ngv - pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_valid <= 1'b0;
        end else if (en) begin
            r_cls_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cls <= n_cls;
        end
    end

    // Multiply stage (index 0) and divider stages (indexes 1 to NDIV).
    rhsv_pkg::t_div r_div [0:NDIV];
    rhsv_pkg::t_div n_div [0:NDIV];
    logic [NDIV:0]  r_div_valid;

    always_comb begin
        n_div[0].hrem   = rhsv_pkg::NUM_W'(r_cls.diff) *
                          rhsv_pkg::NUM_W'(rhsv_pkg::HUE_SECTOR);
        n_div[0].srem   = rhsv_pkg::NUM_W'(r_cls.chroma) *
                          rhsv_pkg::NUM_W'(rhsv_pkg::SAT_SCALE);
        n_div[0].hq     = '0;
        n_div[0].sq     = '0;
        n_div[0].chroma = r_cls.chroma;
        n_div[0].bright = r_cls.bright;
        n_div[0].neg    = r_cls.neg;
        n_div[0].bias   = r_cls.bias;
    end

    // Each divider stage resolves one quotient bit of both divisions.
    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        localparam int SH = NDIV - k;

        always_comb begin
            logic [rhsv_pkg::NUM_W-1:0] hden;
            logic [rhsv_pkg::NUM_W-1:0] sden;
            hden     = rhsv_pkg::NUM_W'(r_div[k-1].chroma) << SH;
            sden     = rhsv_pkg::NUM_W'(r_div[k-1].bright) << SH;
            n_div[k] = r_div[k-1];
            if (r_div[k-1].hrem >= hden) begin
                n_div[k].hrem   = r_div[k-1].hrem - hden;
                n_div[k].hq[SH] = 1'b1;
            end
            if (r_div[k-1].srem >= sden) begin
                n_div[k].srem   = r_div[k-1].srem - sden;
                n_div[k].sq[SH] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_valid <= '0;
        end else if (en) begin
            r_div_valid <= {r_div_valid[NDIV-1:0], r_cls_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= NDIV; j++) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    // Output stage: apply the hue bias and the grey and black special cases.
    logic [rhsv_pkg::HUE_W-1:0]    r_hue;
    logic [rhsv_pkg::SAMPLE_W-1:0] r_sat;
    logic [rhsv_pkg::SAMPLE_W-1:0] r_bright;
    logic [rhsv_pkg::HUE_W-1:0]    n_hue;
    logic [rhsv_pkg::SAMPLE_W-1:0] n_sat;

    always_comb begin
        logic [rhsv_pkg::HUE_W-1:0] q;
        q = r_div[NDIV].hq[rhsv_pkg::HUE_W-1:0];
        if (r_div[NDIV].chroma == '0) begin
            n_hue = '0;
        end else if (r_div[NDIV].neg) begin
            n_hue = r_div[NDIV].bias - q;
        end else begin
            n_hue = r_div[NDIV].bias + q;
        end
        n_sat = (r_div[NDIV].bright == '0) ? '0 : r_div[NDIV].sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_div_valid[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= r_div[NDIV].bright;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.hue        = r_hue;
    assign o_res.saturation = r_sat;
    assign o_res.brightness = r_bright;

    // Hue never leaves the color wheel.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.hue <= rhsv_pkg::HUE_FULL))
        else $error("hue out of range");

    // A black pixel cannot carry saturation.
    a_sat_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.brightness == '0)) |-> (o_res.saturation == '0))
        else $error("saturation on a black pixel");

    // A stalled result holds the input side closed.
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_pix.ready)
        else $error("input open while output is stalled");

    // An accepted pixel enters the classify stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_cls_valid)
        else $error("accepted pixel lost at classify stage");

endmodule

`default_nettype wire
